/* hw/rtl/upd_pkg.sv */
// ----------------------------------------------------------------------------
// upd_pkg
// types, character codes and hex helpers shared by the url decoder files
// ----------------------------------------------------------------------------
package upd_pkg;

   typedef logic [7:0]  char_type;
   typedef logic [1:0]  kind_type;
   typedef logic [15:0] cap_type;
   typedef logic [15:0] count_type;

   // result kinds
   localparam kind_type KIND_DATA  = 2'd0;
   localparam kind_type KIND_END   = 2'd1;
   localparam kind_type KIND_TRUNC = 2'd2;

   // character codes
   localparam char_type CHR_NUL     = 8'h00;
   localparam char_type CHR_PCT     = 8'h25;
   localparam char_type CHR_QMARK   = 8'h3F;
   localparam char_type CHR_SPACE   = 8'h20;
   localparam char_type CHR_DIGIT0  = 8'h30;
   localparam char_type CHR_LOWER_A = 8'h61;
   localparam char_type CHR_UPPER_A = 8'h41;

   localparam cap_type CAP_RESET = 16'd256;

   // result queue: one waiting word plus the three words of one byte
   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      char_type data;
      kind_type kind;
      logic     last;
   } rsp_word_type;

   function automatic logic is_dec(input char_type c);
      return (c >= CHR_DIGIT0) && (c <= CHR_DIGIT0 + 8'd9);
   endfunction

   function automatic logic is_lower_hex(input char_type c);
      return (c >= CHR_LOWER_A) && (c <= CHR_LOWER_A + 8'd5);
   endfunction

   function automatic logic is_upper_hex(input char_type c);
      return (c >= CHR_UPPER_A) && (c <= CHR_UPPER_A + 8'd5);
   endfunction

   function automatic logic hex_valid(input char_type c);
      return is_dec(c) || is_lower_hex(c) || is_upper_hex(c);
   endfunction

   function automatic logic [3:0] hex_nibble(input char_type c);
      char_type v;
      begin
         if (is_dec(c)) begin
            v = c - CHR_DIGIT0;
         end else if (is_lower_hex(c)) begin
            v = c - CHR_LOWER_A + 8'd10;
         end else begin
            v = c - CHR_UPPER_A + 8'd10;
         end
         return v[3:0];
      end
   endfunction

   function automatic logic is_term(input char_type c);
      return (c == CHR_NUL) || (c == CHR_QMARK) || (c == CHR_SPACE);
   endfunction

endpackage

/* hw/rtl/upd_if.sv */
// ----------------------------------------------------------------------------
// upd channel interfaces
// valid/ready channels for source bytes, results and the capacity register
// ----------------------------------------------------------------------------
interface upd_req_if;
   logic               valid;
   logic               ready;
   upd_pkg::char_type  in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface upd_rsp_if;
   logic               valid;
   logic               ready;
   upd_pkg::char_type  out_byte;
   upd_pkg::kind_type  out_kind;
   logic               out_last;

   modport source (output valid, output out_byte, output out_kind, output out_last,
                   input ready);
   modport sink   (input valid, input out_byte, input out_kind, input out_last,
                   output ready);
endinterface

interface upd_csr_if;
   logic               valid;
   logic               ready;
   upd_pkg::cap_type   out_capacity;

   modport source (output valid, output out_capacity, input ready);
   modport sink   (input valid, input out_capacity, output ready);
endinterface

/* hw/rtl/url_percent_decoder_unit.sv */
// ----------------------------------------------------------------------------
// url_percent_decoder_unit
// percent decoder for url paths, one source byte per word, with capacity limit
// ----------------------------------------------------------------------------
//
//  channel    dir  payload                          word
//  req_chan   in   in_byte[7:0]                      one source byte
//  rsp_chan   out  out_byte[7:0] out_kind[1:0] last  one decoded byte or end mark
//  csr_chan   in   out_capacity[15:0]                capacity incl. terminator
//
// a source byte is decoded in the cycle it is taken and its zero to three
// result words land in a four-word result queue; one word leaves per cycle
// while rsp ready is high; req ready is high while the queue holds at most one
// word, so with rsp ready high a byte is taken every cycle if it causes at most
// one result; a failed escape gives up to three words and may keep req ready low
// until the queue is down to one word; synchronous active-high reset: normal
// mode, count zero, queue empty, capacity 256; csr writes are taken every cycle
//
module url_percent_decoder_unit (
   input logic        clock,
   input logic        reset,
   upd_req_if.sink    req_chan,
   upd_rsp_if.source  rsp_chan,
   upd_csr_if.sink    csr_chan
);
   import upd_pkg::*;

   // parse modes, one-hot
   typedef enum logic [3:0] {
      MODE_NORMAL = 4'b0001,
      MODE_PCT    = 4'b0010,
      MODE_DIGIT  = 4'b0100,
      MODE_SKIP   = 4'b1000
   } mode_type;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   // architectural state
   mode_type   mode_ff, mode_in;
   char_type   held_ff, held_in;
   count_type  written_ff, written_in;
   cap_type    cap_ff;

   // result queue, head at entry zero
   rsp_word_type          queue_ff [QUEUE_DEPTH];
   rsp_word_type          queue_in [QUEUE_DEPTH];
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   // decode results of the current byte
   rsp_word_type          res [MAX_RESULTS];
   logic [1:0]            res_n;

   logic       push;
   logic       pop;
   char_type   b;

   // escape prefix stage
   logic [1:0] pre_n;
   logic       do_plain;
   count_type  w_mid;
   logic [16:0] w_plus3;
   logic [16:0] w_plus1;
   logic [CNT_W-1:0] base;

   assign b = req_chan.in_byte;

   assign req_chan.ready = (cnt_ff <= CNT_W'(1));
   assign push = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid    = (cnt_ff != '0);
   assign rsp_chan.out_byte = queue_ff[0].data;
   assign rsp_chan.out_kind = queue_ff[0].kind;
   assign rsp_chan.out_last = queue_ff[0].last;
   assign pop = rsp_chan.valid && rsp_chan.ready;

   assign csr_chan.ready = 1'b1;

   assign w_plus3 = {1'b0, w_mid} + 17'd3;
   assign w_plus1 = {1'b0, w_mid} + 17'd1;

   // byte decode: escape handling first, then the ordinary byte rules
   always_comb begin
      mode_in    = mode_ff;
      held_in    = held_ff;
      written_in = written_ff;
      pre_n      = 2'd0;
      do_plain   = 1'b0;
      w_mid      = written_ff;
      for (int j = 0; j < MAX_RESULTS; j++) begin
         res[j] = '{data: CHR_NUL, kind: KIND_DATA, last: 1'b0};
      end

      case (mode_ff)
         MODE_SKIP: begin
            if (b == CHR_NUL) begin
               mode_in    = MODE_NORMAL;
               written_in = '0;
            end
         end
         MODE_PCT: begin
            if (hex_valid(b)) begin
               held_in = b;
               mode_in = MODE_DIGIT;
            end else begin
               // lone percent goes out as is
               res[0]   = '{data: CHR_PCT, kind: KIND_DATA, last: 1'b0};
               pre_n    = 2'd1;
               w_mid    = written_ff + 16'd1;
               do_plain = 1'b1;
            end
         end
         MODE_DIGIT: begin
            if (hex_valid(held_ff) && hex_valid(b)) begin
               res[0]     = '{data: {hex_nibble(held_ff), hex_nibble(b)},
                              kind: KIND_DATA, last: 1'b0};
               pre_n      = 2'd1;
               written_in = written_ff + 16'd1;
               mode_in    = MODE_NORMAL;
            end else begin
               // percent and held digit replayed, current byte handled plainly
               res[0]   = '{data: CHR_PCT, kind: KIND_DATA, last: 1'b0};
               res[1]   = '{data: held_ff, kind: KIND_DATA, last: 1'b0};
               pre_n    = 2'd2;
               w_mid    = written_ff + 16'd2;
               do_plain = 1'b1;
            end
         end
         default: begin
            do_plain = 1'b1;
         end
      endcase

      res_n = pre_n;
      if (do_plain) begin
         written_in = w_mid;
         mode_in    = MODE_NORMAL;
         if (is_term(b)) begin
            res[pre_n] = '{data: CHR_NUL, kind: KIND_END, last: 1'b0};
            res_n      = pre_n + 2'd1;
            if (b == CHR_NUL) begin
               written_in = '0;
            end else begin
               mode_in = MODE_SKIP;
            end
         end else if (b == CHR_PCT && w_plus3 < {1'b0, cap_ff}) begin
            mode_in = MODE_PCT;
         end else if (w_plus1 >= {1'b0, cap_ff}) begin
            // no room left for a literal byte
            res[pre_n] = '{data: CHR_NUL, kind: KIND_TRUNC, last: 1'b0};
            res_n      = pre_n + 2'd1;
            mode_in    = MODE_SKIP;
         end else begin
            res[pre_n] = '{data: b, kind: KIND_DATA, last: 1'b0};
            res_n      = pre_n + 2'd1;
            written_in = w_mid + 16'd1;
         end
      end

      if (res_n != 2'd0) begin
         res[res_n - 2'd1].last = 1'b1;
      end
   end

   // result queue: shift on pop, append decode results behind what remains
   assign base = cnt_ff - CNT_W'(pop);

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         queue_in[i] = pop ? queue_ff[i+1] : queue_ff[i];
      end
      queue_in[QUEUE_DEPTH-1] = queue_ff[QUEUE_DEPTH-1];
      if (push) begin
         for (int j = 0; j < MAX_RESULTS; j++) begin
            if (2'(j) < res_n) begin
               queue_in[base[IDX_W-1:0] + IDX_W'(j)] = res[j];
            end
         end
      end
      cnt_in = base + (push ? CNT_W'(res_n) : CNT_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         held_ff    <= '0;
         written_ff <= '0;
         cap_ff     <= CAP_RESET;
         cnt_ff     <= '0;
      end else begin
         if (push) begin
            mode_ff    <= mode_in;
            held_ff    <= held_in;
            written_ff <= written_in;
         end
         if (csr_chan.valid) begin
            cap_ff <= csr_chan.out_capacity;
         end
         cnt_ff <= cnt_in;
      end
   end

   // payload words need no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

   // queue never overfills
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   // a word that is not last always has its successor already queued
   a_not_last_has_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.out_last) |-> cnt_ff >= CNT_W'(2))
      else $error("non-last word without follower");

   // end marks close the results of their byte
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.out_kind != KIND_DATA) |-> rsp_chan.out_last)
      else $error("end mark not last");

   // the held digit of a pending escape is hex
   a_held_hex: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_DIGIT) |-> hex_valid(held_ff))
      else $error("held digit not hex");

   // reset empties the queue
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> cnt_ff == '0)
      else $error("queue not empty after reset");

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// url percent decoder testbench
// drives source bytes and capacity writes into url_percent_decoder_unit,
// predicts every result word with a cycle-free model of the decoder and
// checks the words in order while both sides stall at random
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import upd_pkg::*;

   // decoder scan states, mirrored in the predictor
   typedef enum logic [1:0] {
      SCAN_PLAIN,
      SCAN_PERCENT,
      SCAN_DIGIT,
      SCAN_DISCARD
   } scan_mode_type;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES   = 28;
   localparam int MAX_REPORTS   = 60;

   logic clock;
   logic reset;

   upd_req_if req_bus ();
   upd_rsp_if rsp_bus ();
   upd_csr_if csr_bus ();

   url_percent_decoder_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source),
      .csr_chan (csr_bus.sink)
   );

   // predictor state
   cap_type       cap_shadow;
   scan_mode_type scan_mode;
   char_type      first_digit;
   count_type     bytes_written;

   // words of the byte being predicted, then all words still owed by the dut
   rsp_word_type  step_words[$];
   rsp_word_type  decoded_q[$];

   // source bytes not yet taken by the dut; the head is the one on the bus
   char_type      byte_backlog[$];

   int  error_count;
   int  cycle_count;
   int  bytes_taken;
   int  words_checked;
   int  items_queued;
   int  cap_writes;
   bit  quiet;

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // value of a hex digit, -1 when not one
   function automatic int nibble_of(input char_type c);
      if (c >= CHR_DIGIT0 && c <= CHR_DIGIT0 + 8'd9) return int'(c - CHR_DIGIT0);
      if (c >= CHR_LOWER_A && c <= CHR_LOWER_A + 8'd5) return int'(c - CHR_LOWER_A) + 10;
      if (c >= CHR_UPPER_A && c <= CHR_UPPER_A + 8'd5) return int'(c - CHR_UPPER_A) + 10;
      return -1;
   endfunction

   function automatic void emit_word(input char_type data, input kind_type kind);
      rsp_word_type w;
      w.data = data;
      w.kind = kind;
      w.last = 1'b0;
      step_words.push_back(w);
   endfunction

   // an ordinary byte: terminator, escape start, truncation or a copy
   function automatic void plain_byte(input char_type b);
      int cap;
      int cnt;
      cap = int'(cap_shadow);
      cnt = int'(bytes_written);
      if (b == CHR_NUL || b == CHR_QMARK || b == CHR_SPACE) begin
         emit_word(8'h00, KIND_END);
         if (b == CHR_NUL) begin
            scan_mode = SCAN_PLAIN;
            bytes_written = '0;
         end else begin
            scan_mode = SCAN_DISCARD;
         end
      end else if (b == CHR_PCT && cnt < cap - 3) begin
         // escape only admitted with room for the decoded byte
         scan_mode = SCAN_PERCENT;
      end else if (cnt >= cap - 1) begin
         emit_word(8'h00, KIND_TRUNC);
         scan_mode = SCAN_DISCARD;
      end else begin
         emit_word(b, KIND_DATA);
         bytes_written = bytes_written + 16'd1;
         scan_mode = SCAN_PLAIN;
      end
   endfunction

   // one accepted source byte: append its expected words to decoded_q
   function automatic void decode_byte(input char_type b);
      int hi;
      int lo;
      step_words = {};
      case (scan_mode)
         SCAN_DISCARD: begin
            if (b == CHR_NUL) begin
               scan_mode = SCAN_PLAIN;
               bytes_written = '0;
            end
         end
         SCAN_PERCENT: begin
            if (nibble_of(b) >= 0) begin
               first_digit = b;
               scan_mode = SCAN_DIGIT;
            end else begin
               // failed escape: literal percent, byte handled as ordinary
               emit_word(CHR_PCT, KIND_DATA);
               bytes_written = bytes_written + 16'd1;
               scan_mode = SCAN_PLAIN;
               plain_byte(b);
            end
         end
         SCAN_DIGIT: begin
            hi = nibble_of(first_digit);
            lo = nibble_of(b);
            if (hi >= 0 && lo >= 0) begin
               emit_word(char_type'((hi << 4) | lo), KIND_DATA);
               bytes_written = bytes_written + 16'd1;
               scan_mode = SCAN_PLAIN;
            end else begin
               // failed second digit: percent and held digit replayed
               emit_word(CHR_PCT, KIND_DATA);
               emit_word(first_digit, KIND_DATA);
               bytes_written = bytes_written + 16'd2;
               scan_mode = SCAN_PLAIN;
               plain_byte(b);
            end
         end
         default: plain_byte(b);
      endcase
      if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
      foreach (step_words[i]) decoded_q.push_back(step_words[i]);
   endfunction

   // ------------------------------------------------------------------
   // mismatch report
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("[%0d] word %0d: %s got %0d expected %0d",
                  cycle_count, words_checked, what, got, want);
   endtask

   // ------------------------------------------------------------------
   // driver: one source byte per word, random gaps, valid held until taken
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.in_byte <= 8'h00;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(req_bus.in_byte);
            bytes_taken++;
            void'(byte_backlog.pop_front());
         end
         if (req_bus.valid && !req_bus.ready) begin
            // word still on offer, keep it stable
         end else if (byte_backlog.size() > 0 &&
                      (quiet || $urandom_range(0, 99) >= 20)) begin
            req_bus.valid   <= 1'b1;
            req_bus.in_byte <= byte_backlog[0];
         end else begin
            req_bus.valid   <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: compare each accepted result word with the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (decoded_q.size() == 0) begin
               report_mismatch("unexpected word, kind", int'(rsp_bus.out_kind), -1);
            end else begin
               want = decoded_q.pop_front();
               if (rsp_bus.out_kind !== want.kind)
                  report_mismatch("out_kind", int'(rsp_bus.out_kind), int'(want.kind));
               if (rsp_bus.out_byte !== want.data)
                  report_mismatch("out_byte", int'(rsp_bus.out_byte), int'(want.data));
               if (rsp_bus.out_last !== want.last)
                  report_mismatch("out_last", int'(rsp_bus.out_last), int'(want.last));
            end
            words_checked++;
         end
         // receiver stalls at random except in the quiet stretch
         rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 20);
      end
   end

   // ------------------------------------------------------------------
   // watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("url_percent_decoder_unit: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // counted bytes feed the phase budget; a discarded tail does not
   task automatic add_byte(input char_type b, input bit counted);
      byte_backlog.push_back(b);
      if (counted) items_queued++;
   endtask

   function automatic char_type random_hex();
      int v;
      v = $urandom_range(0, 21);
      if (v < 10) return CHR_DIGIT0 + char_type'(v);
      if (v < 16) return CHR_LOWER_A + char_type'(v - 10);
      return CHR_UPPER_A + char_type'(v - 16);
   endfunction

   function automatic char_type random_non_hex();
      char_type c;
      do c = char_type'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
      return c;
   endfunction

   // a byte that is copied as is: no terminator, no percent
   function automatic char_type random_literal();
      char_type c;
      do begin
         if ($urandom_range(0, 4) != 0) c = char_type'($urandom_range(8'h21, 8'h7E));
         else c = char_type'($urandom_range(1, 255));
      end while (c == CHR_PCT || c == CHR_QMARK || c == CHR_SPACE);
      return c;
   endfunction

   // well-formed path: literals and escapes, some broken, then a terminator
   task automatic add_string();
      int tokens;
      int sel;
      int tail;
      tokens = $urandom_range(0, 8);
      repeat (tokens) begin
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            add_byte(random_literal(), 1'b1);
         end else if (sel < 75) begin
            add_byte(CHR_PCT, 1'b1);
            add_byte(random_hex(), 1'b1);
            add_byte(random_hex(), 1'b1);
         end else if (sel < 85) begin
            add_byte(CHR_PCT, 1'b1);
            add_byte(random_non_hex(), 1'b1);
         end else if (sel < 95) begin
            add_byte(CHR_PCT, 1'b1);
            add_byte(random_hex(), 1'b1);
            add_byte(random_non_hex(), 1'b1);
         end else begin
            add_byte(char_type'($urandom_range(0, 255)), 1'b1);
         end
      end
      sel = $urandom_range(0, 3);
      if (sel < 2) begin
         add_byte(CHR_NUL, 1'b1);
      end else begin
         add_byte(sel == 2 ? CHR_QMARK : CHR_SPACE, 1'b1);
         // query or trailing text that the decoder skips
         tail = $urandom_range(0, 3);
         repeat (tail) add_byte(char_type'($urandom_range(1, 255)), 1'b0);
         add_byte(CHR_NUL, 1'b1);
      end
   endtask

   // raw noise, resynchronized by a zero byte
   task automatic add_noise();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) add_byte(char_type'($urandom_range(0, 255)), 1'b1);
      add_byte(CHR_NUL, 1'b1);
   endtask

   // sender holds off until every byte is taken and every word has come
   task automatic drain();
      while (byte_backlog.size() != 0 || decoded_q.size() != 0) @(posedge clock);
   endtask

   // a byte may still be in the decoder with no word owed, so pad a little
   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input cap_type value);
      @(posedge clock);
      csr_bus.valid        <= 1'b1;
      csr_bus.out_capacity <= value;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      cap_shadow = value;
      cap_writes++;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_phase(input int budget, input bit pause_midway);
      int start;
      bit paused;
      start = items_queued;
      paused = 1'b0;
      while (items_queued - start < budget) begin
         if (pause_midway && !paused && items_queued - start >= budget / 2) begin
            drain();
            paused = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) add_noise();
         else add_string();
      end
      settle();
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      int wait_cycles;
      // every dut input known from time zero
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.in_byte      = 8'h00;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.out_capacity = CAP_RESET;
      quiet                = 1'b0;
      error_count          = 0;
      cycle_count          = 0;
      bytes_taken          = 0;
      words_checked        = 0;
      items_queued         = 0;
      cap_writes           = 0;
      cap_shadow           = CAP_RESET;
      scan_mode            = SCAN_PLAIN;
      first_digit          = 8'h00;
      bytes_written        = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed words at reset capacity
      // good escapes in both letter cases
      add_byte(CHR_PCT, 1'b1); add_byte("4", 1'b1); add_byte("1", 1'b1);
      add_byte(CHR_PCT, 1'b1); add_byte("f", 1'b1); add_byte("F", 1'b1);
      add_byte(CHR_PCT, 1'b1); add_byte("0", 1'b1); add_byte("0", 1'b1);
      // first digit fails just below the digit range
      add_byte(CHR_PCT, 1'b1); add_byte("/", 1'b1);
      // second digit fails just above the digit range
      add_byte(CHR_PCT, 1'b1); add_byte("9", 1'b1); add_byte(":", 1'b1);
      // second digit fails just past the upper letters
      add_byte(CHR_PCT, 1'b1); add_byte("a", 1'b1); add_byte("G", 1'b1);
      // highest byte as a literal
      add_byte(8'hFF, 1'b1);
      // percent right before the string end
      add_byte(CHR_PCT, 1'b1); add_byte(CHR_NUL, 1'b1);
      // question mark ends the path, the query is skipped
      add_byte(CHR_QMARK, 1'b1); add_byte("x", 1'b0); add_byte(CHR_NUL, 1'b1);
      // space ends the path
      add_byte(CHR_SPACE, 1'b1); add_byte(CHR_NUL, 1'b1);
      settle();

      // capacity sweep, tight limits first so truncation and refused escapes show
      write_capacity(16'd4);
      run_phase(PHASE_BYTES, 1'b0);
      write_capacity(16'd1);
      run_phase(PHASE_BYTES, 1'b0);
      write_capacity(16'd2);
      run_phase(PHASE_BYTES, 1'b0);
      write_capacity(16'd3);
      run_phase(PHASE_BYTES, 1'b0);
      write_capacity(16'd5);
      run_phase(PHASE_BYTES, 1'b1);

      // largest capacity with no stalls on either side
      quiet = 1'b1;
      write_capacity(16'hFFFF);
      run_phase(PHASE_BYTES, 1'b0);
      quiet = 1'b0;

      write_capacity(cap_type'($urandom_range(6, 40)));
      run_phase(PHASE_BYTES, 1'b0);
      write_capacity(cap_type'($urandom_range(1, 65535)));
      run_phase(PHASE_BYTES, 1'b0);
      write_capacity(CAP_RESET);
      run_phase(PHASE_BYTES, 1'b0);

      // final drain with its own bound, then an idle stretch before the checks
      wait_cycles = 0;
      while ((byte_backlog.size() != 0 || decoded_q.size() != 0) && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (16) @(posedge clock);
      if (decoded_q.size() != 0)
         report_mismatch("words never delivered", 0, decoded_q.size());

      $display("run covered %0d source bytes and %0d result words over %0d capacity writes",
               bytes_taken, words_checked, cap_writes);
      $display("capacities from 1 to 65535, escapes good and broken, all three terminators");
      if (error_count == 0) begin
         $display("url_percent_decoder_unit: match");
      end else begin
         $display("url_percent_decoder_unit: mismatch");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/upd_pkg.sv
hw/rtl/upd_if.sv
hw/rtl/url_percent_decoder_unit.sv
sim/testbench.sv
